@@ hw/rtl/ers_pkg.sv @@
// Shared types, widths and register codes for the ellipse row span block.
package ers_pkg;

  localparam int MAX_DIM = 4096;
  localparam int XW      = $clog2(MAX_DIM);
  localparam int WW      = XW + 1;
  localparam int ITERS   = XW;
  localparam int CFW     = 64;
  localparam int BW      = CFW + XW + 2;
  localparam int CW      = CFW + 2 * XW + 3;
  localparam int TW      = CFW + XW + 3;
  localparam int QW      = TW + XW + 2;
  localparam int IMG_W   = 13;
  localparam int CFG_IW  = 3;

  localparam logic [IMG_W-1:0] IMG_WIDTH_RESET = 13'd4096;

  typedef enum logic [CFG_IW-1:0] {
    REG_COEF_XX    = 3'd0,
    REG_COEF_XY    = 3'd1,
    REG_COEF_X     = 3'd2,
    REG_COEF_YY    = 3'd3,
    REG_COEF_Y     = 3'd4,
    REG_COEF_CONST = 3'd5,
    REG_IMG_WIDTH  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [BW-1:0] b;
    logic signed [CW-1:0] c;
    logic [XW-1:0]        lo;
    logic [XW-1:0]        hi;
    logic [XW-1:0]        lo2;
    logic [XW-1:0]        hi2;
    logic                 hit;
  } item_t;

endpackage

@@ hw/rtl/ers_row_terms.sv @@
// Two stages that form the linear and constant row terms of the quadratic.
module ers_row_terms (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_v,
  input  logic [ers_pkg::XW-1:0]       row,
  input  logic signed [ers_pkg::CFW-1:0] coef_xy,
  input  logic signed [ers_pkg::CFW-1:0] coef_x,
  input  logic signed [ers_pkg::CFW-1:0] coef_yy,
  input  logic signed [ers_pkg::CFW-1:0] coef_y,
  input  logic signed [ers_pkg::CFW-1:0] coef_const,
  input  logic [ers_pkg::XW-1:0]       w_hi,
  output logic                         out_v,
  output ers_pkg::item_t               out_item
);
  import ers_pkg::*;

  logic                 v1;
  logic [XW-1:0]        y1;
  logic signed [BW-1:0] u1;
  logic signed [BW-1:0] b1;
  logic signed [BW-1:0] u_next;
  logic signed [BW-1:0] b_next;
  logic signed [CW-1:0] c_next;

  always_comb begin
    u_next = coef_yy * $signed({1'b0, row}) + coef_y;
    b_next = coef_xy * $signed({1'b0, row}) + coef_x;
    c_next = u1 * $signed({1'b0, y1}) + coef_const;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v1    <= in_v;
      out_v <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y1           <= row;
      u1           <= u_next;
      b1           <= b_next;
      out_item.b   <= b1;
      out_item.c   <= c_next;
      out_item.lo  <= '0;
      out_item.hi  <= w_hi;
      out_item.lo2 <= '0;
      out_item.hi2 <= '0;
      out_item.hit <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/ers_min_step.sv @@
// One bisection step toward the column where the row quadratic is smallest.
module ers_min_step (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic signed [ers_pkg::CFW-1:0] coef_xx,
  input  logic                           in_v,
  input  ers_pkg::item_t                 in_item,
  output logic                           out_v,
  output ers_pkg::item_t                 out_item
);
  import ers_pkg::*;

  logic                 va;
  item_t                ia;
  logic [XW-1:0]        mida;
  logic signed [TW-1:0] pa;
  logic [XW-1:0]        mid;
  logic signed [TW-1:0] p_next;
  item_t                item_next;

  always_comb begin
    mid    = in_item.lo + ((in_item.hi - in_item.lo) >> 1);
    p_next = coef_xx * $signed({1'b0, mid, 1'b1}) + in_item.b;
  end

  always_comb begin
    item_next = ia;
    if (ia.lo < ia.hi) begin
      if (!pa[TW-1]) begin
        item_next.hi = mida;
      end else begin
        item_next.lo = mida + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      va    <= in_v;
      out_v <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ia       <= in_item;
      mida     <= mid;
      pa       <= p_next;
      out_item <= item_next;
    end
  end

endmodule

@@ hw/rtl/ers_check.sv @@
// Tests the quadratic at its minimum column and seeds the left and right edge searches.
module ers_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic signed [ers_pkg::CFW-1:0] coef_xx,
  input  logic [ers_pkg::XW-1:0]         w_hi,
  input  logic                           in_v,
  input  ers_pkg::item_t                 in_item,
  output logic                           out_v,
  output ers_pkg::item_t                 out_item
);
  import ers_pkg::*;

  logic                 va;
  item_t                ia;
  logic signed [TW-1:0] ta;
  logic signed [TW-1:0] t_next;
  logic signed [QW-1:0] q;
  item_t                item_next;

  always_comb begin
    t_next = coef_xx * $signed({1'b0, in_item.lo}) + in_item.b;
  end

  always_comb begin
    q             = ta * $signed({1'b0, ia.lo}) + ia.c;
    item_next     = ia;
    item_next.hit = q[QW-1] || (q == '0);
    item_next.lo  = '0;
    item_next.hi  = ia.lo;
    item_next.lo2 = ia.lo;
    item_next.hi2 = w_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      va    <= in_v;
      out_v <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ia       <= in_item;
      ta       <= t_next;
      out_item <= item_next;
    end
  end

endmodule

@@ hw/rtl/ers_edge_step.sv @@
// One bisection step of the left and right span edge searches side by side.
module ers_edge_step (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic signed [ers_pkg::CFW-1:0] coef_xx,
  input  logic                           in_v,
  input  ers_pkg::item_t                 in_item,
  output logic                           out_v,
  output ers_pkg::item_t                 out_item
);
  import ers_pkg::*;

  logic                 va;
  item_t                ia;
  logic [XW-1:0]        mid1a;
  logic [XW-1:0]        mid2a;
  logic signed [TW-1:0] t1a;
  logic signed [TW-1:0] t2a;
  logic [XW-1:0]        mid1;
  logic [XW-1:0]        mid2;
  logic [WW-1:0]        span2;
  logic signed [TW-1:0] t1_next;
  logic signed [TW-1:0] t2_next;
  logic signed [QW-1:0] q1;
  logic signed [QW-1:0] q2;
  item_t                item_next;

  always_comb begin
    mid1    = in_item.lo + ((in_item.hi - in_item.lo) >> 1);
    span2   = {1'b0, in_item.hi2 - in_item.lo2} + 1'b1;
    mid2    = in_item.lo2 + XW'(span2 >> 1);
    t1_next = coef_xx * $signed({1'b0, mid1}) + in_item.b;
    t2_next = coef_xx * $signed({1'b0, mid2}) + in_item.b;
  end

  always_comb begin
    q1        = t1a * $signed({1'b0, mid1a}) + ia.c;
    q2        = t2a * $signed({1'b0, mid2a}) + ia.c;
    item_next = ia;
    if (ia.lo < ia.hi) begin
      if (q1[QW-1] || (q1 == '0)) begin
        item_next.hi = mid1a;
      end else begin
        item_next.lo = mid1a + 1'b1;
      end
    end
    if (ia.lo2 < ia.hi2) begin
      if (q2[QW-1] || (q2 == '0)) begin
        item_next.lo2 = mid2a;
      end else begin
        item_next.hi2 = mid2a - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      va    <= in_v;
      out_v <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ia       <= in_item;
      mid1a    <= mid1;
      mid2a    <= mid2;
      t1a      <= t1_next;
      t2a      <= t2_next;
      out_item <= item_next;
    end
  end

endmodule

@@ hw/rtl/ellipse_row_span.sv @@
// Top level of the ellipse row span pipeline with its configuration registers.
//
//   channel   direction  handshake              payload
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//   row       in         in_valid / in_ready    row
//   span      out        out_valid / out_ready  span_valid, span_start, span_end
//
// A request enters every cycle while the output is not stalled; it passes through
// two row-term stages, two stages per step of the minimum search, two for the
// minimum test, two per step of the paired edge searches, and the output register.
// Reset clears all valid bits and sets the coefficients to 0 and the width to 4096.
// A stalled output freezes the whole pipeline, so in_ready drops only in a stall.
module ellipse_row_span (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ers_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [ers_pkg::CFW-1:0]      cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ers_pkg::XW-1:0]       row,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         span_valid,
  output logic [ers_pkg::XW-1:0]       span_start,
  output logic [ers_pkg::WW-1:0]       span_end
);
  import ers_pkg::*;

  logic signed [CFW-1:0] coef_xx;
  logic signed [CFW-1:0] coef_xy;
  logic signed [CFW-1:0] coef_x;
  logic signed [CFW-1:0] coef_yy;
  logic signed [CFW-1:0] coef_y;
  logic signed [CFW-1:0] coef_const;
  logic [IMG_W-1:0]      img_width;

  logic          en;
  logic [WW-1:0] w_eff;
  logic [XW-1:0] w_hi;
  logic          span_ok;

  logic  min_v    [0:ITERS];
  item_t min_item [0:ITERS];
  logic  edge_v    [0:ITERS];
  item_t edge_item [0:ITERS];
  item_t last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_xx    <= '0;
      coef_xy    <= '0;
      coef_x     <= '0;
      coef_yy    <= '0;
      coef_y     <= '0;
      coef_const <= '0;
      img_width  <= IMG_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COEF_XX:    coef_xx    <= cfg_data;
        REG_COEF_XY:    coef_xy    <= cfg_data;
        REG_COEF_X:     coef_x     <= cfg_data;
        REG_COEF_YY:    coef_yy    <= cfg_data;
        REG_COEF_Y:     coef_y     <= cfg_data;
        REG_COEF_CONST: coef_const <= cfg_data;
        REG_IMG_WIDTH:  img_width  <= cfg_data[IMG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff   = (32'(img_width) > MAX_DIM) ? WW'(MAX_DIM) : WW'(img_width);
    w_hi    = (w_eff == '0) ? '0 : XW'(w_eff - 1'b1);
    span_ok = (w_eff != '0) && !coef_xx[CFW-1] && (coef_xx != '0);
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  ers_row_terms u_row_terms (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_v       (in_valid),
    .row        (row),
    .coef_xy    (coef_xy),
    .coef_x     (coef_x),
    .coef_yy    (coef_yy),
    .coef_y     (coef_y),
    .coef_const (coef_const),
    .w_hi       (w_hi),
    .out_v      (min_v[0]),
    .out_item   (min_item[0])
  );

  for (genvar i = 0; i < ITERS; i++) begin : g_min
    ers_min_step u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .coef_xx  (coef_xx),
      .in_v     (min_v[i]),
      .in_item  (min_item[i]),
      .out_v    (min_v[i+1]),
      .out_item (min_item[i+1])
    );
  end

  ers_check u_check (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .coef_xx  (coef_xx),
    .w_hi     (w_hi),
    .in_v     (min_v[ITERS]),
    .in_item  (min_item[ITERS]),
    .out_v    (edge_v[0]),
    .out_item (edge_item[0])
  );

  for (genvar i = 0; i < ITERS; i++) begin : g_edge
    ers_edge_step u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .coef_xx  (coef_xx),
      .in_v     (edge_v[i]),
      .in_item  (edge_item[i]),
      .out_v    (edge_v[i+1]),
      .out_item (edge_item[i+1])
    );
  end

  assign last = edge_item[ITERS];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= edge_v[ITERS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      span_valid <= last.hit && span_ok;
      span_start <= (last.hit && span_ok) ? last.lo : '0;
      span_end   <= (last.hit && span_ok) ? WW'(last.lo2) + 1'b1 : '0;
    end
  end

`ifndef SYNTH
  a_span_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && span_valid |-> ({1'b0, span_start} < span_end))
    else $error("span start is not left of span end");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !span_valid |-> (span_start == '0) && (span_end == '0))
    else $error("empty span carries nonzero columns");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(span_end) && $stable(edge_v[ITERS]))
    else $error("pipeline moved during an output stall");
`endif

endmodule

@@ test/ellipse_row_span_checker.sv @@
// Checker for the ellipse row span block: predicts each span and compares it on the output.
`timescale 1ns / 1ps
module ellipse_row_span_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [ers_pkg::CFG_IW-1:0] cfg_index,
  input  logic [ers_pkg::CFW-1:0]    cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [ers_pkg::XW-1:0]     row,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       span_valid,
  input  logic [ers_pkg::XW-1:0]     span_start,
  input  logic [ers_pkg::WW-1:0]     span_end,
  output int                         fail_count,
  output int                         pending,
  output int                         rows_done,
  output int                         spans_hit
);
  import ers_pkg::*;

  typedef struct packed {
    logic          hit;
    logic [XW-1:0] first;
    logic [WW-1:0] after;
  } span_t;

  logic signed [CFW-1:0] k_xx, k_xy, k_x, k_yy, k_y, k_c;
  logic [IMG_W-1:0]      width_reg;
  span_t                 span_queue[$];

  function automatic logic signed [127:0] row_quad(logic signed [127:0] a, logic signed [127:0] b,
                                                   logic signed [127:0] c, int unsigned x);
    logic signed [127:0] xs;
    xs = $signed({96'd0, x});
    return (a * xs + b) * xs + c;
  endfunction

  function automatic span_t span_of_row(logic [XW-1:0] y);
    span_t               s;
    logic signed [127:0] a, b, c, ys;
    int unsigned         w, lo, hi, mid, m;
    s  = '0;
    w  = width_reg;
    if (w > MAX_DIM) w = MAX_DIM;
    if (w == 0 || k_xx <= 0) return s;
    ys = $signed({116'd0, y});
    a  = k_xx;
    b  = $signed(k_xy) * ys + $signed(k_x);
    c  = ($signed(k_yy) * ys + $signed(k_y)) * ys + $signed(k_c);
    lo = 0;
    hi = w - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (a * $signed({96'd0, 2 * mid + 1}) + b >= 0) hi = mid;
      else lo = mid + 1;
    end
    m = lo;
    if (row_quad(a, b, c, m) > 0) return s;
    lo = 0;
    hi = m;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (row_quad(a, b, c, mid) <= 0) hi = mid;
      else lo = mid + 1;
    end
    s.first = lo[XW-1:0];
    lo = m;
    hi = w - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (row_quad(a, b, c, mid) <= 0) lo = mid;
      else hi = mid - 1;
    end
    s.after = WW'(lo + 1);
    s.hit   = 1'b1;
    return s;
  endfunction

  assign pending = span_queue.size();

  always @(posedge clk) begin
    span_t want;
    if (rst) begin
      k_xx <= '0; k_xy <= '0; k_x <= '0; k_yy <= '0; k_y <= '0; k_c <= '0;
      width_reg <= IMG_WIDTH_RESET;
      span_queue.delete();
      fail_count <= 0;
      rows_done <= 0;
      spans_hit <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_COEF_XX:    k_xx <= cfg_data;
          REG_COEF_XY:    k_xy <= cfg_data;
          REG_COEF_X:     k_x <= cfg_data;
          REG_COEF_YY:    k_yy <= cfg_data;
          REG_COEF_Y:     k_y <= cfg_data;
          REG_COEF_CONST: k_c <= cfg_data;
          REG_IMG_WIDTH:  width_reg <= cfg_data[IMG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) span_queue.push_back(span_of_row(row));
      if (out_valid && out_ready) begin
        rows_done <= rows_done + 1;
        if (span_queue.size() == 0) begin
          $error("span with no request waiting");
          fail_count <= fail_count + 1;
        end else begin
          want = span_queue.pop_front();
          if (want.hit) spans_hit <= spans_hit + 1;
          if (span_valid !== want.hit || span_start !== want.first || span_end !== want.after) begin
            fail_count <= fail_count + 1;
            if (span_valid !== want.hit)
              $error("span_valid expected %0d got %0d", want.hit, span_valid);
            if (span_start !== want.first)
              $error("span_start expected %0d got %0d", want.first, span_start);
            if (span_end !== want.after)
              $error("span_end expected %0d got %0d", want.after, span_end);
          end
        end
      end
    end
  end

endmodule

@@ test/tb_ellipse_row_span.sv @@
// Testbench top for the ellipse row span block: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_ellipse_row_span;
  import ers_pkg::*;

  localparam int RANDOM_ROWS = 1875;
  localparam int CYCLE_LIMIT = 600000;

  logic              clk, rst;
  logic              cfg_valid, cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFW-1:0]    cfg_data;
  logic              in_valid, in_ready;
  logic [XW-1:0]     row;
  logic              out_valid, out_ready;
  logic              span_valid;
  logic [XW-1:0]     span_start;
  logic [WW-1:0]     span_end;
  int                fail_count, pending, rows_done, spans_hit;
  int                cycles, sent, stall_left, cy_cur, ry_cur;
  bit                calm;

  ellipse_row_span DUT (.*);
  ellipse_row_span_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_ellipse_row_span: FAIL");
      $finish;
    end
  end

  function automatic int gap_len();
    if (calm) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_row(logic [XW-1:0] r);
    int gap;
    gap = gap_len();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    row <= r;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Axis-aligned ellipse scaled by k, plus a shear term.
  task automatic load_ellipse(int cx, int cy, int rx, int ry, int k,
                              logic signed [63:0] xy, logic [IMG_W-1:0] w);
    logic signed [127:0] xx, yy, cc;
    xx = 128'(ry) * ry * k;
    yy = 128'(rx) * rx * k;
    cc = 128'(cx) * cx * xx + 128'(cy) * cy * yy - xx * rx * rx;
    write_reg(REG_COEF_XX, xx[63:0]);
    write_reg(REG_COEF_XY, xy);
    write_reg(REG_COEF_X, 64'(-2 * cx * xx));
    write_reg(REG_COEF_YY, yy[63:0]);
    write_reg(REG_COEF_Y, 64'(-2 * cy * yy));
    write_reg(REG_COEF_CONST, cc[63:0]);
    write_reg(REG_IMG_WIDTH, 64'(w));
    cy_cur = cy;
    ry_cur = ry;
  endtask

  task automatic load_noise();
    write_reg(REG_COEF_XX, {$urandom, $urandom});
    write_reg(REG_COEF_XY, {$urandom, $urandom});
    write_reg(REG_COEF_X, {$urandom, $urandom});
    write_reg(REG_COEF_YY, {$urandom, $urandom});
    write_reg(REG_COEF_Y, {$urandom, $urandom});
    write_reg(REG_COEF_CONST, {$urandom, $urandom});
    write_reg(REG_IMG_WIDTH, {$urandom, $urandom});
    cy_cur = $urandom_range(0, 4095);
    ry_cur = 2048;
  endtask

  initial begin
    int n, w, rx, ry;
    logic signed [63:0] shear;
    cycles = 0;
    sent = 0;
    calm = 1'b1;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_COEF_XX;
    cfg_data = '0;
    in_valid = 1'b0;
    row = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset coefficients describe no ellipse.
    send_row(0);
    send_row(4095);
    drain();
    load_ellipse(100, 100, 50, 50, 1, 0, 4096);
    send_row(0); send_row(50); send_row(100); send_row(150); send_row(4095);
    drain();
    // Span starts left of the image.
    load_ellipse(-20, 60, 40, 40, 3, 0, 4096);
    send_row(60); send_row(25);
    drain();
    // Span runs past a narrow image.
    load_ellipse(190, 30, 40, 20, 2, 0, 200);
    send_row(30); send_row(10);
    drain();
    load_ellipse(4000, 4090, 300, 300, 1, 0, 8191);
    send_row(4095); send_row(4000);
    drain();
    load_ellipse(0, 0, 10, 10, 1, 0, 1);
    send_row(0); send_row(9);
    drain();
    load_ellipse(50, 50, 30, 30, 1, 0, 0);
    send_row(50);
    drain();
    load_ellipse(50, 50, 30, 30, 1, 0, 4096);
    write_reg(REG_COEF_XX, 64'h8000_0000_0000_0000);
    send_row(50);
    drain();
    write_reg(REG_COEF_XX, 64'h7fff_ffff_ffff_ffff);
    send_row(50); send_row(0);
    drain();

    while (sent < RANDOM_ROWS + 25) begin
      calm = ($urandom_range(0, 5) == 0);
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 4096);
      if ($urandom_range(0, 4) == 0) w = (w & 1) ? 4096 : 1;
      if ($urandom_range(0, 5) == 0) begin
        load_noise();
      end else begin
        rx = $urandom_range(1, 2048);
        ry = $urandom_range(1, 2048);
        shear = ($urandom_range(0, 2) == 0) ? 64'($signed($urandom_range(0, 4096)) - 2048) : 0;
        load_ellipse($signed($urandom_range(0, 5000)) - 500, $urandom_range(0, 4095), rx, ry,
                     1 << $urandom_range(0, 6), shear, w);
      end
      n = $urandom_range(40, 200);
      repeat (n) begin
        if ($urandom_range(0, 2) == 0) send_row($urandom_range(0, 4095));
        else send_row(XW'(cy_cur + $signed($urandom_range(0, 2 * ry_cur)) - ry_cur));
      end
      drain();
    end

    $display("Rows checked: %0d, of which %0d gave a span; %0d rows sent.",
             rows_done, spans_hit, sent);
    $display("Settings covered include reset, clamped, degenerate, zero and oversized widths.");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_ellipse_row_span: PASS");
    end else begin
      $display("tb_ellipse_row_span: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ers_pkg.sv
hw/rtl/ers_row_terms.sv
hw/rtl/ers_min_step.sv
hw/rtl/ers_check.sv
hw/rtl/ers_edge_step.sv
hw/rtl/ellipse_row_span.sv
test/ellipse_row_span_checker.sv
test/tb_ellipse_row_span.sv
